@@ src/ppm_pkg.sv @@
// shared types and constants for the ppm pulse train decoder
// no dependencies; compiled first
`default_nettype none

package ppm_pkg;

	localparam int TICK_W   = 15;
	localparam int WORD_W   = 32;
	localparam int EMITTER_BIT = 31;

	// build defaults for the top level parameters
	localparam int DATA_BITS_DEF       = 32;
	localparam int BITS_PER_SYMBOL_DEF = 2;
	localparam int TICKS_PER_UNIT_DEF  = 16;

	localparam logic [TICK_W-1:0] TOL_RESET = TICK_W'(4);
	localparam logic [TICK_W-1:0] PAD_RESET = TICK_W'(0);

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE = 1'b0,
		REG_PAD       = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [TICK_W-1:0] tolerance;
		logic [TICK_W-1:0] pad;
	} cfg_t;

endpackage

`default_nettype wire

@@ src/ppm_if.sv @@
// valid/ready channels for captured pulse items and decoded words
// depends on ppm_pkg
`default_nettype none

interface ppm_item_if;
	import ppm_pkg::*;

	logic              valid;
	logic              ready;
	logic              start_of_frame;
	logic [TICK_W-1:0] pulse_ticks;
	logic              gap_level;
	logic [TICK_W-1:0] gap_ticks;

	modport source (
		output valid, start_of_frame, pulse_ticks, gap_level, gap_ticks,
		input  ready
	);
	modport sink (
		input  valid, start_of_frame, pulse_ticks, gap_level, gap_ticks,
		output ready
	);
endinterface

interface ppm_result_if;
	import ppm_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data_word;
	logic              accepted;

	modport source (
		output valid, data_word, accepted,
		input  ready
	);
	modport sink (
		input  valid, data_word, accepted,
		output ready
	);
endinterface

`default_nettype wire

@@ src/ppm_sym_dec.sv @@
// symbol decode for one gap: padding, tolerance, quantizing and range check
// depends on ppm_pkg
`default_nettype none

module ppm_sym_dec #(
	parameter int BITS_PER_SYMBOL = ppm_pkg::BITS_PER_SYMBOL_DEF,
	parameter int TICKS_PER_UNIT  = ppm_pkg::TICKS_PER_UNIT_DEF
) (
	input  ppm_pkg::cfg_t                 cfg,
	input  logic [ppm_pkg::TICK_W-1:0]    gap_ticks,
	input  logic [BITS_PER_SYMBOL-1:0]    last_symbol,
	output logic                          bad,
	output logic [BITS_PER_SYMBOL-1:0]    symbol
);
	import ppm_pkg::*;

	localparam int SLACK_W = TICK_W + 1;
	localparam int CUR_W   = SLACK_W + 1;
	// reciprocal for an exact floor divide of any SLACK_W-bit value
	localparam int SHIFT   = SLACK_W + $clog2(TICKS_PER_UNIT);
	localparam int MUL_W   = SLACK_W + 2;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << SHIFT) + TICKS_PER_UNIT - 1) / TICKS_PER_UNIT;
	localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_FULL);
	localparam int SYM_ONE = 1 << BITS_PER_SYMBOL;

	logic [SLACK_W-1:0]       slack;
	logic [SLACK_W-1:0]       net;
	logic [SLACK_W+MUL_W-1:0] prod;
	logic [SLACK_W-1:0]       quot;
	logic [CUR_W-1:0]         cur;

	always_comb begin
		slack  = SLACK_W'(gap_ticks) + SLACK_W'(cfg.tolerance);
		net    = slack - SLACK_W'(cfg.pad);
		prod   = (SLACK_W+MUL_W)'(net) * (SLACK_W+MUL_W)'(RECIP);
		quot   = SLACK_W'(prod >> SHIFT);
		cur    = CUR_W'(last_symbol) + CUR_W'(1) + CUR_W'(quot);
		bad    = (gap_ticks == '0) || (slack < SLACK_W'(cfg.pad))
			|| (cur < CUR_W'(SYM_ONE)) || (cur >= CUR_W'(2 * SYM_ONE));
		// subtracting one symbol span leaves the low bits unchanged
		symbol = cur[BITS_PER_SYMBOL-1:0];
	end

endmodule

`default_nettype wire

@@ src/ppm_pulse_train_decoder.sv @@
// ppm pulse train decoder: one input register, frame state, one result register
// a frame's final item goes from the input register to the result register, which shows its result
// throughput: one item per cycle; only a held result stalls the final item
// arst_n clears frame state, the item and result stages, and loads
// tolerance 4 and padding 0; depends on ppm_pkg, ppm_if, ppm_sym_dec
`default_nettype none

module ppm_pulse_train_decoder #(
	parameter int DATA_BITS       = ppm_pkg::DATA_BITS_DEF,
	parameter int BITS_PER_SYMBOL = ppm_pkg::BITS_PER_SYMBOL_DEF,
	parameter int TICKS_PER_UNIT  = ppm_pkg::TICKS_PER_UNIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [ppm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppm_pkg::TICK_W-1:0]      cfg_wdata,
	ppm_item_if.sink                        items,
	ppm_result_if.source                    results
);
	import ppm_pkg::*;

	localparam int SYMS   = DATA_BITS / BITS_PER_SYMBOL;
	localparam int IDX_W  = $clog2(SYMS + 2);
	localparam int SH_W   = $clog2(DATA_BITS);
	localparam int THR_W  = TICK_W + 1;

	// configuration
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance <= TOL_RESET;
			cfg_q.pad       <= PAD_RESET;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_TOLERANCE: cfg_q.tolerance <= cfg_wdata;
				REG_PAD:       cfg_q.pad       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input stage
	logic              valid_s1;
	logic              sof_s1;
	logic [TICK_W-1:0] pulse_s1;
	logic              glevel_s1;
	logic [TICK_W-1:0] gap_s1;

	// frame state
	logic [IDX_W-1:0]           idx_q;
	logic [BITS_PER_SYMBOL-1:0] last_q;
	logic [WORD_W-1:0]          sum_q;
	logic                       err_q;
	logic                       in_frame_q;

	// result stage
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_acc_q;

	logic [IDX_W-1:0]           idx_e;
	logic [BITS_PER_SYMBOL-1:0] last_e;
	logic [WORD_W-1:0]          sum_e;
	logic                       err_e;
	logic                       in_frame_e;
	logic                       is_sym;
	logic                       is_final;
	logic                       sym_bad;
	logic [BITS_PER_SYMBOL-1:0] sym;
	logic [SH_W-1:0]            sh;
	logic                       emitter_hi;
	logic                       frame_ok;
	logic                       out_free;
	logic                       go_s1;

	logic [IDX_W-1:0]           idx_d;
	logic [BITS_PER_SYMBOL-1:0] last_d;
	logic [WORD_W-1:0]          sum_d;
	logic                       err_d;
	logic                       in_frame_d;

	ppm_sym_dec #(
		.BITS_PER_SYMBOL (BITS_PER_SYMBOL),
		.TICKS_PER_UNIT  (TICKS_PER_UNIT)
	) u_sym_dec (
		.cfg         (cfg_q),
		.gap_ticks   (gap_s1),
		.last_symbol (last_e),
		.bad         (sym_bad),
		.symbol      (sym)
	);

	always_comb begin
		// a start flag opens a fresh frame, dropping any open one
		idx_e      = sof_s1 ? '0 : idx_q;
		last_e     = sof_s1 ? '1 : last_q;
		sum_e      = sof_s1 ? '0 : sum_q;
		err_e      = (sof_s1 ? 1'b0 : err_q) || ((idx_e == '0) && glevel_s1);
		in_frame_e = sof_s1 || in_frame_q;

		is_sym   = in_frame_e && (idx_e < IDX_W'(SYMS));
		is_final = in_frame_e && !(idx_e < IDX_W'(SYMS));

		sh         = SH_W'(32'(idx_e) * BITS_PER_SYMBOL);
		emitter_hi = THR_W'(pulse_s1) > (THR_W'(TICKS_PER_UNIT) + THR_W'(cfg_q.tolerance));
		frame_ok   = !err_e && (gap_s1 == '0);

		idx_d      = idx_e;
		last_d     = last_e;
		sum_d      = sum_e;
		err_d      = err_e;
		in_frame_d = in_frame_e;
		if (is_sym) begin
			idx_d = idx_e + IDX_W'(1);
			if (!err_e) begin
				err_d = sym_bad;
				if (!sym_bad) begin
					last_d = sym;
					sum_d  = sum_e + (WORD_W'(sym) << sh);
				end
			end
		end else if (is_final) begin
			idx_d      = '0;
			in_frame_d = 1'b0;
		end

		out_free    = !out_valid_q || results.ready;
		go_s1       = valid_s1 && (!is_final || out_free);
		items.ready = !valid_s1 || go_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			sof_s1    <= items.start_of_frame;
			pulse_s1  <= items.pulse_ticks;
			glevel_s1 <= items.gap_level;
			gap_s1    <= items.gap_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			last_q     <= '1;
			sum_q      <= '0;
			err_q      <= 1'b0;
			in_frame_q <= 1'b0;
		end else if (go_s1) begin
			idx_q      <= idx_d;
			last_q     <= last_d;
			sum_q      <= sum_d;
			err_q      <= err_d;
			in_frame_q <= in_frame_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && is_final) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_final) begin
			// emitter flag folds into the top bit: adding 2^31 flips it
			out_word_q <= frame_ok
				? {sum_e[WORD_W-1] ^ emitter_hi, sum_e[WORD_W-2:0]} : '0;
			out_acc_q  <= frame_ok;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.data_word = out_word_q;
	assign results.accepted  = out_acc_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(SYMS))
		else $error("item index past end of frame");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> idx_q == '0)
		else $error("item index nonzero outside a frame");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_acc_q |-> out_word_q == '0)
		else $error("rejected frame carries a nonzero word");

	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && is_final |=> out_valid_q)
		else $error("final item gave no result");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |=> out_valid_q && $stable(out_word_q))
		else $error("held result lost or changed");

endmodule

`default_nettype wire

@@ bench/ppm_decode_monitor.sv @@
`timescale 1ns / 100ps
// monitor for the ppm pulse train decoder: decodes every accepted item itself
// and compares each decoded word, in order, with the block's results
// depends on ppm_pkg and the ppm_item_if / ppm_result_if interfaces

module ppm_decode_monitor
	import ppm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_wdata,
	ppm_item_if                  items,
	ppm_result_if                results,
	output int                   mismatches,
	output int                   pending,
	output int                   words_checked
);

	localparam int SYMBOLS  = DATA_BITS_DEF / BITS_PER_SYMBOL_DEF;
	localparam int SYM_SPAN = 1 << BITS_PER_SYMBOL_DEF;
	localparam int TPU      = TICKS_PER_UNIT_DEF;

	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic              accepted;
	} decoded_word_t;

	decoded_word_t expected_words[$];
	decoded_word_t want;

	logic [TICK_W-1:0]              tolerance;
	logic [TICK_W-1:0]              padding;
	logic [4:0]                     sym_count;
	logic [BITS_PER_SYMBOL_DEF-1:0] prev_sym;
	logic [WORD_W-1:0]              word_acc;
	logic                           frame_bad;
	logic                           frame_open;
	int                             fail_count;
	int                             seen;

	task automatic decode_item(input logic sof, input logic [TICK_W-1:0] pulse,
			input logic level, input logic [TICK_W-1:0] gap);
		int unsigned slack;
		int unsigned step;
		int unsigned sym;
		logic [WORD_W-1:0] word;
		if (sof) begin
			sym_count  = '0;
			prev_sym   = '1;
			word_acc   = '0;
			frame_bad  = 1'b0;
			frame_open = 1'b1;
		end
		if (!frame_open)
			return;
		if (sym_count == 0 && level)
			frame_bad = 1'b1;
		if (sym_count < SYMBOLS) begin
			if (!frame_bad) begin
				slack = gap + tolerance;
				if (gap == 0 || slack < padding) begin
					frame_bad = 1'b1;
				end else begin
					// gap gives the step from the previous symbol
					step = (slack - padding) / TPU;
					sym  = prev_sym + 1 + step;
					if (sym < SYM_SPAN || sym >= 2 * SYM_SPAN) begin
						frame_bad = 1'b1;
					end else begin
						sym -= SYM_SPAN;
						prev_sym = sym[BITS_PER_SYMBOL_DEF-1:0];
						word_acc += WORD_W'(sym) << (sym_count * BITS_PER_SYMBOL_DEF);
					end
				end
			end
			sym_count++;
		end else begin
			word = word_acc;
			// long pulse on the closing item means the upper emitter
			if (pulse > TPU + tolerance)
				word += WORD_W'(1) << EMITTER_BIT;
			if (!frame_bad && gap == 0)
				expected_words.push_back(decoded_word_t'{word, 1'b1});
			else
				expected_words.push_back(decoded_word_t'{'0, 1'b0});
			frame_open = 1'b0;
			sym_count  = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance  = TOL_RESET;
			padding    = PAD_RESET;
			sym_count  = '0;
			prev_sym   = '1;
			word_acc   = '0;
			frame_bad  = 1'b0;
			frame_open = 1'b0;
			expected_words.delete();
			fail_count = 0;
			seen       = 0;
			mismatches    <= 0;
			pending       <= 0;
			words_checked <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_TOLERANCE: tolerance = cfg_wdata;
					REG_PAD:       padding   = cfg_wdata;
					default: ;
				endcase
			end
			if (items.valid && items.ready)
				decode_item(items.start_of_frame, items.pulse_ticks, items.gap_level,
					items.gap_ticks);
			if (results.valid && results.ready) begin
				seen++;
				if (expected_words.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: word %h accepted %b",
							results.data_word, results.accepted);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (want.data_word !== results.data_word ||
							want.accepted !== results.accepted) begin
						if (fail_count < 10)
							$display("mismatch: expected word %h accepted %b, got word %h accepted %b",
								want.data_word, want.accepted, results.data_word,
								results.accepted);
						fail_count++;
					end
				end
			end
			mismatches    <= fail_count;
			pending       <= expected_words.size();
			words_checked <= seen;
		end
	end

endmodule

@@ bench/ppm_pulse_train_decoder_test.sv @@
`timescale 1ns / 100ps
// top of the ppm pulse train decoder bench: clock, reset, frame stimulus,
// register settings and result back-pressure; checking is done in ppm_decode_monitor
// depends on ppm_pkg, ppm_if, ppm_pulse_train_decoder and ppm_decode_monitor

module ppm_pulse_train_decoder_test;
	import ppm_pkg::*;

	localparam int SYMBOLS      = DATA_BITS_DEF / BITS_PER_SYMBOL_DEF;
	localparam int SYM_SPAN     = 1 << BITS_PER_SYMBOL_DEF;
	localparam int TPU          = TICKS_PER_UNIT_DEF;
	localparam int MAX_TICK     = (1 << TICK_W) - 1;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 315;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 500000;

	typedef enum int {
		FLAW_NONE,
		FLAW_FIRST_LEVEL,
		FLAW_ZERO_GAP,
		FLAW_BAD_STEP,
		FLAW_BELOW_PAD,
		FLAW_END_GAP,
		FLAW_RESTART,
		FLAW_RANDOM_GAP
	} frame_flaw_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_wdata;

	int  mismatches;
	int  pending;
	int  words_checked;
	int  tol_now       = 4;
	int  pad_now       = 0;
	int  run_sym       = 0;
	int  items_sent    = 0;
	int  frames_sent   = 0;
	int  settings_run  = 0;
	int  cycle_count   = 0;
	int  hold_requests = 0;
	int  hold_served   = 0;
	int  hold_len      = 0;
	bit  calm          = 1'b0;

	ppm_item_if   items();
	ppm_result_if results();

	ppm_pulse_train_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.results   (results)
	);

	ppm_decode_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.items         (items),
		.results       (results),
		.mismatches    (mismatches),
		.pending       (pending),
		.words_checked (words_checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_idle();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99, 0);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// gap that quantizes to the given step under the current settings
	function automatic int gap_for_step(input int step);
		int lo;
		int hi;
		lo = pad_now - tol_now + TPU * step;
		hi = lo + TPU - 1;
		if (lo < 1)
			lo = 1;
		if (hi > MAX_TICK)
			hi = MAX_TICK;
		if (lo > hi)
			return $urandom_range(MAX_TICK, 1);
		return $urandom_range(hi, lo);
	endfunction

	// called at a rising edge; returns at a rising edge
	task automatic send_item(input bit sof, input int pulse, input bit level, input int gap);
		int idle;
		items.valid          <= 1'b1;
		items.start_of_frame <= sof;
		items.pulse_ticks    <= TICK_W'(pulse);
		items.gap_level      <= level;
		items.gap_ticks      <= TICK_W'(gap);
		@(negedge clk);
		while (!items.ready)
			@(negedge clk);
		@(posedge clk);
		idle = pick_idle();
		if (idle > 0) begin
			items.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
	endtask

	task automatic send_frame(input frame_flaw_t flaw);
		int at;
		int s;
		int gap;
		int thr;
		bit level;
		at = (flaw == FLAW_RESTART) ? $urandom_range(SYMBOLS, 1) : $urandom_range(SYMBOLS - 1, 0);
		run_sym = SYM_SPAN - 1;
		for (int i = 0; i < SYMBOLS; i++) begin
			// cut the frame short; the next start item reopens it
			if (flaw == FLAW_RESTART && i == at)
				return;
			s = $urandom_range(SYM_SPAN - 1, 0);
			gap = gap_for_step(s + SYM_SPAN - 1 - run_sym);
			level = (i == 0) ? (flaw == FLAW_FIRST_LEVEL) : 1'($urandom_range(1, 0));
			if (i == at) begin
				case (flaw)
					FLAW_ZERO_GAP: gap = 0;
					FLAW_BAD_STEP: begin
						if (run_sym < SYM_SPAN - 1 && $urandom_range(1, 0))
							gap = gap_for_step($urandom_range(SYM_SPAN - 2 - run_sym, 0));
						else
							gap = gap_for_step(2 * SYM_SPAN - 1 - run_sym + $urandom_range(3, 0));
					end
					FLAW_BELOW_PAD: begin
						if (pad_now - tol_now >= 2)
							gap = $urandom_range(pad_now - tol_now - 1, 1);
						else
							gap = $urandom_range(MAX_TICK, 1);
					end
					FLAW_RANDOM_GAP: gap = $urandom_range(MAX_TICK, 0);
					default: ;
				endcase
			end
			run_sym = s;
			send_item(i == 0, $urandom_range(MAX_TICK, 0), level, gap);
			items_sent++;
		end
		// closing item: pulse often right around the emitter threshold
		thr = TPU + tol_now;
		if ($urandom_range(1, 0)) begin
			s = $urandom_range(thr + 2, thr - 2);
			if (s > MAX_TICK)
				s = MAX_TICK;
		end else begin
			s = $urandom_range(MAX_TICK, 0);
		end
		gap = (flaw == FLAW_END_GAP) ? $urandom_range(MAX_TICK, 1) : 0;
		send_item(1'b0, s, 1'($urandom_range(1, 0)), gap);
		items_sent++;
		frames_sent++;
	endtask

	task automatic random_frames(input int budget);
		int first;
		frame_flaw_t flaw;
		first = items_sent;
		while (items_sent - first < budget) begin
			if ($urandom_range(99, 0) < 55)
				flaw = FLAW_NONE;
			else
				flaw = frame_flaw_t'($urandom_range(FLAW_RANDOM_GAP, FLAW_FIRST_LEVEL));
			send_frame(flaw);
			// stray item between frames, dropped by the block
			if (flaw != FLAW_RESTART && $urandom_range(7, 0) == 0)
				send_item(1'b0, $urandom_range(MAX_TICK, 0), 1'($urandom_range(1, 0)),
					$urandom_range(MAX_TICK, 0));
		end
	endtask

	task automatic drain();
		items.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input int tol, input int pad);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_TOLERANCE;
		cfg_wdata <= TICK_W'(tol);
		@(posedge clk);
		cfg_index <= REG_PAD;
		cfg_wdata <= TICK_W'(pad);
		@(posedge clk);
		cfg_wen <= 1'b0;
		tol_now = tol;
		pad_now = pad;
		settings_run++;
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				stall_left  = hold_len;
			end
			if (stall_left > 0) begin
				results.ready <= 1'b0;
				stall_left--;
			end else begin
				results.ready <= 1'b1;
				stall_left = pick_idle();
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("ppm_pulse_train_decoder_test NOT OK");
		$finish;
	end

	initial begin
		int gap;
		arst_n               <= 1'b0;
		cfg_wen              <= 1'b0;
		cfg_index            <= REG_TOLERANCE;
		cfg_wdata            <= '0;
		items.valid          <= 1'b0;
		items.start_of_frame <= 1'b0;
		items.pulse_ticks    <= '0;
		items.gap_level      <= 1'b0;
		items.gap_ticks      <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray items with no frame open
		send_item(1'b0, 0, 1'b0, 0);
		send_item(1'b0, MAX_TICK, 1'b1, MAX_TICK);
		// frame dropped by a restart, then a clean frame on the upper emitter
		for (int i = 0; i < 3; i++)
			send_item(i == 0, MAX_TICK, 1'b0, i + 1);
		run_sym = SYM_SPAN - 1;
		for (int i = 0; i < SYMBOLS; i++) begin
			gap = gap_for_step(i % SYM_SPAN + SYM_SPAN - 1 - run_sym);
			run_sym = i % SYM_SPAN;
			send_item(i == 0, (i % 2) ? MAX_TICK : 0, 1'b0, gap);
		end
		send_item(1'b0, MAX_TICK, 1'b1, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: apply_setting(0, 0);
					2: apply_setting(MAX_TICK, MAX_TICK);
					3: apply_setting(9, 60);
					4: apply_setting(0, MAX_TICK);
					default: apply_setting($urandom_range(64, 0), $urandom_range(200, 0));
				endcase
			end
			calm <= (ph == 1);
			if (ph == 3) begin
				// results held back while clean frames keep coming
				hold_len      <= 400;
				hold_requests <= hold_requests + 1;
				repeat (3) send_frame(FLAW_NONE);
			end
			random_frames(PHASE_ITEMS);
		end
		drain();

		$display("sent %0d frames (%0d items) over %0d register settings plus reset values",
			frames_sent, items_sent, settings_run);
		$display("compared %0d decoded words, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("ppm_pulse_train_decoder_test OK");
		else
			$display("ppm_pulse_train_decoder_test NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
src/ppm_pkg.sv
src/ppm_if.sv
src/ppm_sym_dec.sv
src/ppm_pulse_train_decoder.sv
bench/ppm_decode_monitor.sv
bench/ppm_pulse_train_decoder_test.sv
